### design/tiled_nonzero_pixel_bounds_defines.svh
// Assertion macros shared by the scan and top-level design files.
// Define ASSERT_OFF to compile every check away.
`ifndef TILED_NONZERO_PIXEL_BOUNDS_DEFINES_SVH
`define TILED_NONZERO_PIXEL_BOUNDS_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked check, switched off while reset is asserted.
`define TNPB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define TNPB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TNPB_ASSERT(label, clk, rst_n, prop, msg)
`define TNPB_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### design/tnpb_pkg.sv
`timescale 1ns / 1ps

package tnpb_pkg;

    localparam int MAX_DIMENSION = 256;
    localparam int POSITION_BITS = 24;
    localparam int TILE_SIDE     = 8;

    localparam int FRAME_BITS     = 8;
    localparam int TILE_BITS      = $clog2(TILE_SIDE);
    localparam int COORD_BITS     = $clog2(MAX_DIMENSION);
    localparam int DIM_BITS       = COORD_BITS + 1;
    localparam int MAX_TILES      = MAX_DIMENSION / TILE_SIDE;
    localparam int TILE_IDX_BITS  = $clog2(MAX_TILES);
    localparam int TILE_CNT_BITS  = TILE_IDX_BITS + 1;
    localparam int AREA_BITS      = 2 * TILE_CNT_BITS;
    localparam int BASE_BITS      = FRAME_BITS + AREA_BITS + 2 * TILE_BITS;
    localparam int CMP_BITS       = (POSITION_BITS > BASE_BITS) ? POSITION_BITS : BASE_BITS;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = DIM_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_SELECT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [FRAME_BITS-1:0] FRAME_RESET = '0;
    localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(32);
    localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(32);

    typedef struct packed {
        logic [TILE_CNT_BITS-1:0] tiles_x;
        logic [TILE_CNT_BITS-1:0] tiles_y;
        logic [BASE_BITS-1:0]     base;
    } t_geom;

    typedef struct packed {
        logic [COORD_BITS-1:0] low_x;
        logic [COORD_BITS-1:0] low_y;
        logic [COORD_BITS-1:0] high_x;
        logic [COORD_BITS-1:0] high_y;
        logic                  any_set;
    } t_bounds;

    typedef struct packed {
        logic [COORD_BITS-1:0] min_x;
        logic [COORD_BITS-1:0] min_y;
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] max_y;
        logic [DIM_BITS-1:0]   box_width;
        logic [DIM_BITS-1:0]   box_height;
        logic [DIM_BITS-1:0]   centre_x_doubled;
        logic [DIM_BITS-1:0]   centre_y_doubled;
        logic                  none_found;
    } t_result;

    // Number of whole tiles along one side, after clamping the dimension
    // to TILE_SIDE .. MAX_DIMENSION and dropping the partial tile.
    function automatic logic [TILE_CNT_BITS-1:0] tiles_of(input logic [DIM_BITS-1:0] dim);
        logic [TILE_CNT_BITS-1:0] t;
        begin
            if (dim > DIM_BITS'(MAX_DIMENSION)) begin
                t = TILE_CNT_BITS'(MAX_TILES);
            end else if (dim < DIM_BITS'(TILE_SIDE)) begin
                t = TILE_CNT_BITS'(1);
            end else begin
                t = dim[DIM_BITS-1:TILE_BITS];
            end
            return t;
        end
    endfunction

endpackage

### design/tnpb_cfg.sv
`timescale 1ns / 1ps

module tnpb_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tnpb_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [tnpb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output tnpb_pkg::t_geom                      o_geom
);

    localparam int PROD_BITS = tnpb_pkg::FRAME_BITS + tnpb_pkg::AREA_BITS;

    logic [tnpb_pkg::FRAME_BITS-1:0]    r_frame_select, n_frame_select;
    logic [tnpb_pkg::DIM_BITS-1:0]      r_image_width,  n_image_width;
    logic [tnpb_pkg::DIM_BITS-1:0]      r_image_height, n_image_height;
    logic [tnpb_pkg::TILE_CNT_BITS-1:0] r_tiles_x, n_tiles_x;
    logic [tnpb_pkg::TILE_CNT_BITS-1:0] r_tiles_y, n_tiles_y;
    logic [tnpb_pkg::AREA_BITS-1:0]     r_area;
    logic [tnpb_pkg::BASE_BITS-1:0]     r_base;
    logic [PROD_BITS-1:0]               frame_area;

    // Next register values, with reset folded in so that the derived
    // geometry is already correct when reset is released.
    always_comb begin
        n_frame_select = r_frame_select;
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        if (!i_rst_n) begin
            n_frame_select = tnpb_pkg::FRAME_RESET;
            n_image_width  = tnpb_pkg::WIDTH_RESET;
            n_image_height = tnpb_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tnpb_pkg::CFG_FRAME_SELECT: begin
                    n_frame_select = i_cfg_data[tnpb_pkg::FRAME_BITS-1:0];
                end
                tnpb_pkg::CFG_IMAGE_WIDTH: begin
                    n_image_width = i_cfg_data;
                end
                tnpb_pkg::CFG_IMAGE_HEIGHT: begin
                    n_image_height = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign n_tiles_x = tnpb_pkg::tiles_of(n_image_width);
    assign n_tiles_y = tnpb_pkg::tiles_of(n_image_height);

    always_ff @(posedge i_clk) begin
        r_frame_select <= n_frame_select;
        r_image_width  <= n_image_width;
        r_image_height <= n_image_height;
    end

    // Offset stages: tile count of the frame, then its start byte.
    assign frame_area = PROD_BITS'(r_frame_select) * PROD_BITS'(r_area);

    always_ff @(posedge i_clk) begin
        r_tiles_x <= n_tiles_x;
        r_tiles_y <= n_tiles_y;
        r_area    <= tnpb_pkg::AREA_BITS'(n_tiles_x) * tnpb_pkg::AREA_BITS'(n_tiles_y);
        r_base    <= {frame_area, {(2 * tnpb_pkg::TILE_BITS){1'b0}}};
    end

    assign o_geom.tiles_x = r_tiles_x;
    assign o_geom.tiles_y = r_tiles_y;
    assign o_geom.base    = r_base;

endmodule

### design/tnpb_scan.sv
`timescale 1ns / 1ps
`include "tiled_nonzero_pixel_bounds_defines.svh"

module tnpb_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_pixel,
    input  logic                  i_last,
    input  tnpb_pkg::t_geom       i_geom,
    output tnpb_pkg::t_bounds     o_bounds
);

    localparam int CB = tnpb_pkg::COORD_BITS;

    logic [tnpb_pkg::POSITION_BITS-1:0] r_position, n_position;
    logic                               r_full, n_full;
    logic [tnpb_pkg::TILE_BITS-1:0]     r_col, n_col;
    logic [tnpb_pkg::TILE_BITS-1:0]     r_row, n_row;
    logic [tnpb_pkg::TILE_IDX_BITS-1:0] r_tile_col, n_tile_col;
    logic [tnpb_pkg::TILE_CNT_BITS-1:0] r_tile_row, n_tile_row;
    logic [CB-1:0]                      r_low_x, r_low_y, r_high_x, r_high_y;
    logic                               r_any_set;

    logic          in_frame;
    logic          hit;
    logic [CB-1:0] x, y;
    tnpb_pkg::t_bounds bounds;

    assign in_frame = !r_full
        && (tnpb_pkg::CMP_BITS'(r_position) >= tnpb_pkg::CMP_BITS'(i_geom.base))
        && (r_tile_row < i_geom.tiles_y);

    assign x   = {r_tile_col, r_col};
    assign y   = {r_tile_row[tnpb_pkg::TILE_IDX_BITS-1:0], r_row};
    assign hit = in_frame && (i_pixel != 8'd0);

    // Bounds including the current byte; these feed the result directly.
    always_comb begin
        bounds.low_x   = (hit && (!r_any_set || x < r_low_x))  ? x : r_low_x;
        bounds.low_y   = (hit && (!r_any_set || y < r_low_y))  ? y : r_low_y;
        bounds.high_x  = (hit && (!r_any_set || x > r_high_x)) ? x : r_high_x;
        bounds.high_y  = (hit && (!r_any_set || y > r_high_y)) ? y : r_high_y;
        bounds.any_set = r_any_set || hit;
    end

    assign o_bounds = bounds;

    // Pixel, tile column and tile row counters walk the tiled layout.
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_tile_col = r_tile_col;
        n_tile_row = r_tile_row;
        if (in_frame) begin
            if (&r_col) begin
                n_col = '0;
                if (&r_row) begin
                    n_row = '0;
                    if ({1'b0, r_tile_col} + 1'b1 >= i_geom.tiles_x) begin
                        n_tile_col = '0;
                        n_tile_row = r_tile_row + 1'b1;
                    end else begin
                        n_tile_col = r_tile_col + 1'b1;
                    end
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // The position stops at all ones and the stream is ignored from there.
    always_comb begin
        n_position = r_position;
        n_full     = r_full;
        if (!r_full) begin
            if (&r_position) begin
                n_full = 1'b1;
            end else begin
                n_position = r_position + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_position <= '0;
            r_full     <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_tile_col <= '0;
            r_tile_row <= '0;
            r_low_x    <= '1;
            r_low_y    <= '1;
            r_high_x   <= '0;
            r_high_y   <= '0;
            r_any_set  <= 1'b0;
        end else if (i_step) begin
            r_position <= n_position;
            r_full     <= n_full;
            r_col      <= n_col;
            r_row      <= n_row;
            r_tile_col <= n_tile_col;
            r_tile_row <= n_tile_row;
            r_low_x    <= bounds.low_x;
            r_low_y    <= bounds.low_y;
            r_high_x   <= bounds.high_x;
            r_high_y   <= bounds.high_y;
            r_any_set  <= bounds.any_set;
        end
    end

    `TNPB_ASSERT(a_bounds_ordered, i_clk, i_rst_n, r_any_set |-> (r_low_x <= r_high_x && r_low_y <= r_high_y), "bounds out of order")
    `TNPB_ASSERT(a_clear_after_last, i_clk, i_rst_n, (i_step && i_last) |=> (r_position == '0 && !r_any_set && !r_full), "scan not cleared after last byte")

endmodule

### design/tnpb_box.sv
`timescale 1ns / 1ps

module tnpb_box (
    input  tnpb_pkg::t_bounds                   i_bounds,
    input  logic [tnpb_pkg::TILE_CNT_BITS-1:0]  i_tiles_x,
    input  logic [tnpb_pkg::TILE_CNT_BITS-1:0]  i_tiles_y,
    output tnpb_pkg::t_result                   o_result
);

    localparam int CB = tnpb_pkg::COORD_BITS;
    localparam int DB = tnpb_pkg::DIM_BITS;

    logic [CB-1:0] x0, y0, x1, y1;
    logic [CB-1:0] frame_x1, frame_y1;

    // Last column and row of the whole frame, for an empty search.
    assign frame_x1 = {tnpb_pkg::TILE_IDX_BITS'(i_tiles_x - 1'b1), {tnpb_pkg::TILE_BITS{1'b1}}};
    assign frame_y1 = {tnpb_pkg::TILE_IDX_BITS'(i_tiles_y - 1'b1), {tnpb_pkg::TILE_BITS{1'b1}}};

    always_comb begin
        if (i_bounds.any_set) begin
            x0 = i_bounds.low_x;
            y0 = i_bounds.low_y;
            x1 = i_bounds.high_x;
            y1 = i_bounds.high_y;
        end else begin
            x0 = '0;
            y0 = '0;
            x1 = frame_x1;
            y1 = frame_y1;
        end
    end

    always_comb begin
        o_result.min_x            = x0;
        o_result.min_y            = y0;
        o_result.max_x            = x1;
        o_result.max_y            = y1;
        o_result.box_width        = DB'(x1) - DB'(x0) + 1'b1;
        o_result.box_height       = DB'(y1) - DB'(y0) + 1'b1;
        o_result.centre_x_doubled = DB'(x0) + DB'(x1) + 1'b1;
        o_result.centre_y_doubled = DB'(y0) + DB'(y1) + 1'b1;
        o_result.none_found       = !i_bounds.any_set;
    end

endmodule

### design/tiled_nonzero_pixel_bounds.sv
`timescale 1ns / 1ps
`include "tiled_nonzero_pixel_bounds_defines.svh"

// Channel   Direction  Handshake                   Payload
// cfg       in         i_cfg_we                    i_cfg_index, i_cfg_data
// pixel     in         i_in_valid / o_in_ready     i_pixel_byte, i_last_byte
// box       out        o_out_valid / i_out_ready   o_min_x .. o_none_found
//
// One pixel transaction is taken every cycle unless a last byte is held; each
// byte passes the input register, and the box for a last byte sits in the
// output register from the following cycle. Only a last byte waits, and only
// while an earlier box has not been taken. A configuration write reaches the
// tile counts through one register and the frame offset through the area or
// frame select register, then the base register. Reset is synchronous and
// active low; it restores the valid flags, configuration and scan.

module tiled_nonzero_pixel_bounds (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_cfg_we,
    input  logic [tnpb_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [tnpb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [7:0]                           i_pixel_byte,
    input  logic                                 i_last_byte,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [7:0]                           o_min_x,
    output logic [7:0]                           o_min_y,
    output logic [7:0]                           o_max_x,
    output logic [7:0]                           o_max_y,
    output logic [8:0]                           o_box_width,
    output logic [8:0]                           o_box_height,
    output logic [8:0]                           o_centre_x_doubled,
    output logic [8:0]                           o_centre_y_doubled,
    output logic                                 o_none_found
);

    tnpb_pkg::t_geom   geom;
    tnpb_pkg::t_bounds bounds;
    tnpb_pkg::t_result result;

    // Input register: one byte and its last flag.
    logic       r_in_valid;
    logic [7:0] r_in_pixel;
    logic       r_in_last;

    // Output register: the finished box.
    logic              r_out_valid;
    tnpb_pkg::t_result r_out;

    logic advance;

    // Configuration registers and the start offset of the selected frame.
    tnpb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    // The held byte moves on unless it closes a stream and the previous box
    // is still waiting to be taken.
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_pixel <= i_pixel_byte;
            r_in_last  <= i_last_byte;
        end
    end

    // Position counters and running bounds; the bounds seen here already
    // include the byte in the input register.
    tnpb_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_pixel  (r_in_pixel),
        .i_last   (r_in_last),
        .i_geom   (geom),
        .o_bounds (bounds)
    );

    // Box corners, size and doubled centre, with the full frame standing in
    // when nothing was found.
    tnpb_box u_box (
        .i_bounds  (bounds),
        .i_tiles_x (geom.tiles_x),
        .i_tiles_y (geom.tiles_y),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_min_x            = r_out.min_x;
    assign o_min_y            = r_out.min_y;
    assign o_max_x            = r_out.max_x;
    assign o_max_y            = r_out.max_y;
    assign o_box_width        = r_out.box_width;
    assign o_box_height       = r_out.box_height;
    assign o_centre_x_doubled = r_out.centre_x_doubled;
    assign o_centre_y_doubled = r_out.centre_y_doubled;
    assign o_none_found       = r_out.none_found;

    `TNPB_ASSERT(a_last_waits, i_clk, i_rst_n, (r_in_valid && r_in_last && r_out_valid && !i_out_ready) |=> (r_in_valid && r_in_last), "last byte lost while box waits")
    `TNPB_ASSERT(a_empty_box_at_origin, i_clk, i_rst_n, (o_out_valid && o_none_found) |-> (o_min_x == 8'd0 && o_min_y == 8'd0), "empty search not at origin")

endmodule
